FILE: hw/rtl/stbs_pkg.sv
// Shared types, codes and the microcode program of the record table.
package stbs_pkg;

   localparam int SCORE_W = 16;
   localparam int TAG_W   = 16;
   localparam int INDEX_W = 7;
   localparam int OP_W    = 2;
   localparam int PC_W    = 4;

   // Request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_LOAD   = 2'd1,
      OP_SORT   = 2'd2,
      OP_SEARCH = 2'd3
   } op_type;

   // Result kinds
   localparam logic KIND_MAX    = 1'b0;
   localparam logic KIND_SEARCH = 1'b1;

   // Memory port action of one step
   typedef enum logic [2:0] {
      MEM_NONE,
      MEM_RD_ZERO,
      MEM_RD_Z,
      MEM_RD_LAST,
      MEM_RD_MID,
      MEM_WR_BEST,
      MEM_WR_END
   } mem_op_type;

   // Pointer register action of one step
   typedef enum logic [2:0] {
      PTR_NONE,
      PTR_END_INIT,
      PTR_Z_SET1,
      PTR_Z_INC,
      PTR_END_DEC,
      PTR_LH_INIT,
      PTR_LH_STEP
   } ptr_op_type;

   // Running maximum action of one step
   typedef enum logic [1:0] {
      BEST_NONE,
      BEST_LOAD,
      BEST_CMP
   } best_op_type;

   // Result source of a finishing step
   typedef enum logic [1:0] {
      RES_NONE,
      RES_CLEAR,
      RES_Q
   } res_op_type;

   // Jump conditions
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_N_LT2,
      COND_N_ZERO,
      COND_Z_LE_END,
      COND_END_NE_ONE,
      COND_LO_GT_HI,
      COND_NOT_HIT
   } cond_type;

   // Program addresses
   localparam logic [PC_W-1:0] PC_SORT  = 4'd0;
   localparam logic [PC_W-1:0] PC_PASS  = 4'd1;
   localparam logic [PC_W-1:0] PC_FIRST = 4'd2;
   localparam logic [PC_W-1:0] PC_SCAN  = 4'd3;
   localparam logic [PC_W-1:0] PC_SWPA  = 4'd4;
   localparam logic [PC_W-1:0] PC_SWPB  = 4'd5;
   localparam logic [PC_W-1:0] PC_RPT   = 4'd6;
   localparam logic [PC_W-1:0] PC_RPTQ  = 4'd7;
   localparam logic [PC_W-1:0] PC_SRCH  = 4'd8;
   localparam logic [PC_W-1:0] PC_TEST  = 4'd9;
   localparam logic [PC_W-1:0] PC_CMP   = 4'd10;
   localparam logic [PC_W-1:0] PC_HIT   = 4'd11;
   localparam logic [PC_W-1:0] PC_MISS  = 4'd12;

   typedef struct packed {
      mem_op_type       mem_op;
      ptr_op_type       ptr_op;
      best_op_type      best_op;
      res_op_type       res_op;
      cond_type         cond;
      logic [PC_W-1:0]  target;
      logic             done;
   } cw_type;

   typedef struct packed {
      logic n_lt2;
      logic n_zero;
      logic z_le_end;
      logic end_ne_one;
      logic lo_gt_hi;
      logic not_hit;
   } flags_type;

   typedef struct packed {
      logic                      load;
      logic                      clear;
      logic                      start;
      logic signed [SCORE_W-1:0] score;
      logic [TAG_W-1:0]          tag;
   } cmd_type;

   typedef struct packed {
      logic                      found;
      logic [INDEX_W-1:0]        index;
      logic signed [SCORE_W-1:0] score;
      logic [TAG_W-1:0]          tag;
   } res_type;

   // Control word that does nothing
   function automatic cw_type idle_word();
      cw_type w;
      w.mem_op  = MEM_NONE;
      w.ptr_op  = PTR_NONE;
      w.best_op = BEST_NONE;
      w.res_op  = RES_NONE;
      w.cond    = COND_NEVER;
      w.target  = PC_SORT;
      w.done    = 1'b0;
      return w;
   endfunction

   // Microcode program: sort at PC_SORT, search at PC_SRCH
   function automatic cw_type ucode_word(input logic [PC_W-1:0] pc);
      cw_type w;
      w = idle_word();
      unique case (pc)
         PC_SORT: begin
            w.ptr_op = PTR_END_INIT;
            w.cond   = COND_N_LT2;
            w.target = PC_RPT;
         end
         PC_PASS: begin
            w.mem_op = MEM_RD_ZERO;
            w.ptr_op = PTR_Z_SET1;
         end
         PC_FIRST: begin
            w.mem_op  = MEM_RD_Z;
            w.ptr_op  = PTR_Z_INC;
            w.best_op = BEST_LOAD;
         end
         PC_SCAN: begin
            w.mem_op  = MEM_RD_Z;
            w.ptr_op  = PTR_Z_INC;
            w.best_op = BEST_CMP;
            w.cond    = COND_Z_LE_END;
            w.target  = PC_SCAN;
         end
         PC_SWPA: begin
            w.mem_op = MEM_WR_BEST;
         end
         PC_SWPB: begin
            w.mem_op = MEM_WR_END;
            w.ptr_op = PTR_END_DEC;
            w.cond   = COND_END_NE_ONE;
            w.target = PC_PASS;
         end
         PC_RPT: begin
            w.mem_op = MEM_RD_LAST;
            w.cond   = COND_N_ZERO;
            w.target = PC_MISS;
         end
         PC_RPTQ: begin
            w.res_op = RES_Q;
            w.done   = 1'b1;
         end
         PC_SRCH: begin
            w.ptr_op = PTR_LH_INIT;
         end
         PC_TEST: begin
            w.mem_op = MEM_RD_MID;
            w.cond   = COND_LO_GT_HI;
            w.target = PC_MISS;
         end
         PC_CMP: begin
            w.ptr_op = PTR_LH_STEP;
            w.cond   = COND_NOT_HIT;
            w.target = PC_TEST;
         end
         PC_HIT: begin
            w.res_op = RES_Q;
            w.done   = 1'b1;
         end
         default: begin
            w.res_op = RES_CLEAR;
            w.done   = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

FILE: hw/rtl/stbs_sequencer.sv
// Step counter and microcode lookup with conditional jumps.
module stbs_sequencer
   import stbs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [PC_W-1:0] start_pc,
   input  logic            stall,
   input  flags_type       flags,
   output cw_type          cw,
   output logic            busy
);

   logic            run_ff, run_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic            cond_true;

   // Fetch the control word, idle when not running
   always_comb begin
      cw = run_ff ? ucode_word(pc_ff) : idle_word();
   end

   // Evaluate the jump condition
   always_comb begin
      unique case (cw.cond)
         COND_NEVER:      cond_true = 1'b0;
         COND_N_LT2:      cond_true = flags.n_lt2;
         COND_N_ZERO:     cond_true = flags.n_zero;
         COND_Z_LE_END:   cond_true = flags.z_le_end;
         COND_END_NE_ONE: cond_true = flags.end_ne_one;
         COND_LO_GT_HI:   cond_true = flags.lo_gt_hi;
         COND_NOT_HIT:    cond_true = flags.not_hit;
         default:         cond_true = 1'b0;
      endcase
   end

   // Advance, jump, or hold on a blocked finishing step
   always_comb begin
      run_in = run_ff;
      pc_in  = pc_ff;
      if (start) begin
         run_in = 1'b1;
         pc_in  = start_pc;
      end else if (run_ff) begin
         if (cw.done) begin
            if (!stall) begin
               run_in = 1'b0;
            end
         end else if (cond_true) begin
            pc_in = cw.target;
         end else begin
            pc_in = pc_ff + PC_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         pc_ff  <= PC_SORT;
      end else begin
         run_ff <= run_in;
         pc_ff  <= pc_in;
      end
   end

   assign busy = run_ff;

endmodule

FILE: hw/rtl/stbs_datapath.sv
// Record memory, pointer registers and compare logic driven by the control word.
module stbs_datapath
   import stbs_pkg::*;
#(
   parameter int DEPTH = 128
)
(
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  cw_type    cw,
   output flags_type flags,
   output res_type   res
);

   localparam int IW    = $clog2(DEPTH);
   localparam int CNW   = $clog2(DEPTH + 1);
   localparam int LW    = IW + 2;
   localparam int REC_W = SCORE_W + TAG_W;

   logic [REC_W-1:0] mem_ram [DEPTH];

   logic [CNW-1:0]          count_ff, count_in;
   logic [IW-1:0]           end_ff, end_in;
   logic [CNW-1:0]          z_ff, z_in;
   logic [IW-1:0]           best_idx_ff, best_idx_in;
   logic [REC_W-1:0]        best_rec_ff, best_rec_in;
   logic signed [LW-1:0]    lo_ff, lo_in;
   logic signed [LW-1:0]    hi_ff, hi_in;
   logic signed [SCORE_W-1:0] key_ff, key_in;
   logic [REC_W-1:0]        q_ff;
   logic [IW-1:0]           rd_idx_ff;

   logic                      rd_en, wr_en;
   logic [IW-1:0]             rd_addr, wr_addr;
   logic [REC_W-1:0]          wr_data;
   logic signed [SCORE_W-1:0] q_score, best_score;
   logic [TAG_W-1:0]          q_tag;
   logic [IW-1:0]             last_idx, mid;
   logic signed [LW:0]        lh_sum;
   logic signed [LW-1:0]      mid_s, cnt_s;
   logic                      full, z_le_end, lo_gt_hi, not_hit;

   // Decode the registered record and the search window
   always_comb begin
      q_score    = signed'(q_ff[REC_W-1 -: SCORE_W]);
      q_tag      = q_ff[TAG_W-1:0];
      best_score = signed'(best_rec_ff[REC_W-1 -: SCORE_W]);
      last_idx   = IW'(count_ff - CNW'(1));
      lh_sum     = {lo_ff[LW-1], lo_ff} + {hi_ff[LW-1], hi_ff};
      mid        = lh_sum[IW:1];
      mid_s      = signed'({2'b00, mid});
      cnt_s      = signed'(LW'(count_ff));
      full       = (count_ff >= CNW'(DEPTH));
      z_le_end   = (z_ff <= CNW'(end_ff));
      lo_gt_hi   = (lo_ff > hi_ff);
      not_hit    = (q_score != key_ff);
   end

   always_comb begin
      flags.n_lt2      = (count_ff < CNW'(2));
      flags.n_zero     = (count_ff == '0);
      flags.z_le_end   = z_le_end;
      flags.end_ne_one = (end_ff != IW'(1));
      flags.lo_gt_hi   = lo_gt_hi;
      flags.not_hit    = not_hit;
   end

   // Select the memory access of this step, or the load beat
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = q_ff;
      unique case (cw.mem_op)
         MEM_RD_ZERO: begin
            rd_en = 1'b1;
         end
         MEM_RD_Z: begin
            rd_en   = z_le_end;
            rd_addr = z_ff[IW-1:0];
         end
         MEM_RD_LAST: begin
            rd_en   = (count_ff != '0);
            rd_addr = last_idx;
         end
         MEM_RD_MID: begin
            rd_en   = !lo_gt_hi;
            rd_addr = mid;
         end
         MEM_WR_BEST: begin
            wr_en   = 1'b1;
            wr_addr = best_idx_ff;
            wr_data = q_ff;
         end
         MEM_WR_END: begin
            wr_en   = 1'b1;
            wr_addr = end_ff;
            wr_data = best_rec_ff;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
      if (cmd.load && !full) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[IW-1:0];
         wr_data = {cmd.score, cmd.tag};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ram[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff      <= mem_ram[rd_addr];
         rd_idx_ff <= rd_addr;
      end
   end

   // Update pass end, scan index and search bounds
   always_comb begin
      end_in = end_ff;
      z_in   = z_ff;
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      unique case (cw.ptr_op)
         PTR_END_INIT: end_in = last_idx;
         PTR_Z_SET1:   z_in   = CNW'(1);
         PTR_Z_INC: begin
            if (z_le_end) begin
               z_in = z_ff + CNW'(1);
            end
         end
         PTR_END_DEC:  end_in = end_ff - IW'(1);
         PTR_LH_INIT: begin
            lo_in = '0;
            hi_in = cnt_s - LW'(1);
         end
         PTR_LH_STEP: begin
            if (not_hit) begin
               if (q_score < key_ff) begin
                  lo_in = mid_s + LW'(1);
               end else begin
                  hi_in = mid_s - LW'(1);
               end
            end
         end
         default: begin
            end_in = end_ff;
         end
      endcase
   end

   // Track the first maximum of the pass
   always_comb begin
      best_idx_in = best_idx_ff;
      best_rec_in = best_rec_ff;
      unique case (cw.best_op)
         BEST_LOAD: begin
            best_idx_in = rd_idx_ff;
            best_rec_in = q_ff;
         end
         BEST_CMP: begin
            if (best_score < q_score) begin
               best_idx_in = rd_idx_ff;
               best_rec_in = q_ff;
            end
         end
         default: begin
            best_idx_in = best_idx_ff;
         end
      endcase
   end

   // Fill count and search key
   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.load && !full) begin
         count_in = count_ff + CNW'(1);
      end
      key_in = cmd.start ? cmd.score : key_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      end_ff      <= end_in;
      z_ff        <= z_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      best_idx_ff <= best_idx_in;
      best_rec_ff <= best_rec_in;
      key_ff      <= key_in;
   end

   // Form the result of a finishing step
   always_comb begin
      res.found = (cw.res_op == RES_Q);
      res.index = res.found ? INDEX_W'(rd_idx_ff) : '0;
      res.score = res.found ? q_score : '0;
      res.tag   = res.found ? q_tag : '0;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNW'(DEPTH))
      else $error("entry count beyond capacity");

   a_read_in_table: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (CNW'(rd_addr) < count_ff))
      else $error("read outside the filled table");

   a_best_in_prefix: assert property (@(posedge clock) disable iff (reset)
      (cw.best_op == BEST_CMP) |-> (best_idx_ff <= end_ff))
      else $error("running maximum outside the unsorted prefix");

   a_swap_pair: assert property (@(posedge clock) disable iff (reset)
      (cw.mem_op == MEM_WR_END) |-> ($past(cw.mem_op) == MEM_WR_BEST))
      else $error("end write without its swap partner");

endmodule

FILE: hw/rtl/sort_then_binary_search_table.sv
// Top level of the sorted record table: handshakes, sequencer, datapath, result register.
//
// A table of up to DEPTH records, each a signed 16-bit score with a 16-bit tag.
// Clear and load beats give no result; a load into a full table is dropped. A
// sort beat orders the table ascending by selection sort and returns the last
// entry as the maximum, or zeros for an empty table; its run time is set by the
// single read port of the record memory, which the maximum scan walks one entry
// per cycle, and by the swap that ends each pass. A search beat binary-searches
// for the key and returns index, score and tag, or zeros when the key is absent;
// each probe waits for one registered memory read. One item is worked at a time:
// req_ready is low while a sort or search runs. The result sits in an output
// register, so clear and load beats are taken while a result waits on rsp_ready.
// The stores need no clearing after reset.
module sort_then_binary_search_table
   import stbs_pkg::*;
#(
   parameter int DEPTH = 128
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [OP_W-1:0]           req_op,
   input  logic signed [SCORE_W-1:0] req_score_in,
   input  logic [TAG_W-1:0]          req_tag_in,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_result_kind,
   output logic                      rsp_found,
   output logic [INDEX_W-1:0]        rsp_index_out,
   output logic signed [SCORE_W-1:0] rsp_score_out,
   output logic [TAG_W-1:0]          rsp_tag_out
);

   op_type          op;
   logic            req_fire, start, stall, done_fire, busy;
   logic [PC_W-1:0] start_pc;
   cmd_type         cmd;
   cw_type          cw;
   flags_type       flags;
   res_type         res;

   logic    kind_ff, kind_in;
   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_res_ff, rsp_res_in;
   logic    rsp_kind_ff, rsp_kind_in;

   // Decode the request beat
   always_comb begin
      op        = op_type'(req_op);
      req_ready = !busy;
      req_fire  = req_valid && req_ready;
      start     = req_fire && ((op == OP_SORT) || (op == OP_SEARCH));
      start_pc  = (op == OP_SORT) ? PC_SORT : PC_SRCH;
      cmd.load  = req_fire && (op == OP_LOAD);
      cmd.clear = req_fire && (op == OP_CLEAR);
      cmd.start = start;
      cmd.score = req_score_in;
      cmd.tag   = req_tag_in;
      kind_in   = kind_ff;
      if (start) begin
         kind_in = (op == OP_SEARCH) ? KIND_SEARCH : KIND_MAX;
      end
   end

   // Hold the finishing step while the result register is still full
   always_comb begin
      stall     = rsp_valid_ff && !rsp_ready;
      done_fire = cw.done && !stall;
   end

   stbs_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .start_pc (start_pc),
      .stall    (stall),
      .flags    (flags),
      .cw       (cw),
      .busy     (busy)
   );

   stbs_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .cw    (cw),
      .flags (flags),
      .res   (res)
   );

   // Load the result register, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_kind_in  = rsp_kind_ff;
      if (done_fire) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
         rsp_kind_in  = kind_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_found       = rsp_res_ff.found;
   assign rsp_index_out   = rsp_res_ff.index;
   assign rsp_score_out   = rsp_res_ff.score;
   assign rsp_tag_out     = rsp_res_ff.tag;

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start |=> !req_ready)
      else $error("request taken while a sort or search runs");

   a_done_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      done_fire |=> (rsp_valid && (rsp_result_kind == $past(kind_ff))))
      else $error("finished result not registered with its kind");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !done_fire)
      else $error("result overwritten before it was taken");

endmodule

FILE: sim/tb_sort_then_binary_search_table.sv
// Self-checking testbench for the sorted record table: directed and random op sequences.
module tb_sort_then_binary_search_table;
   timeunit 1ns;
   timeprecision 1ps;
   import stbs_pkg::*;

   localparam int DEPTH       = 128;
   localparam int RAND_ITEMS  = 1350;
   localparam int HOLD_AT     = 300;
   localparam int HOLD_CYCLES = 400;
   localparam int STEADY_LO   = 600;
   localparam int STEADY_HI   = 900;
   localparam int DRAIN_WAIT  = 32;

   typedef struct {
      op_type                    op;
      logic signed [SCORE_W-1:0] score;
      logic [TAG_W-1:0]          tag;
   } table_req_type;

   typedef struct {
      logic                      kind;
      logic                      found;
      logic [INDEX_W-1:0]        index;
      logic signed [SCORE_W-1:0] score;
      logic [TAG_W-1:0]          tag;
   } table_report_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [OP_W-1:0]           req_op = '0;
   logic signed [SCORE_W-1:0] req_score_in = '0;
   logic [TAG_W-1:0]          req_tag_in = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_result_kind;
   logic                      rsp_found;
   logic [INDEX_W-1:0]        rsp_index_out;
   logic signed [SCORE_W-1:0] rsp_score_out;
   logic [TAG_W-1:0]          rsp_tag_out;

   // Beats waiting to be offered, and reports waiting to arrive
   table_req_type    req_backlog [$];
   table_report_type pending_reports [$];

   // Shadow copy of the record table
   logic signed [SCORE_W-1:0] shadow_score [DEPTH];
   logic [TAG_W-1:0]          shadow_tag [DEPTH];
   int                        shadow_count = 0;

   // Generator view of the table, used to pick keys that hit
   logic signed [SCORE_W-1:0] gen_scores [$];
   int                        gen_count = 0;
   int                        queued = 0;

   bit req_took = 1'b0;
   int req_beats = 0;
   int fail_count = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   sort_then_binary_search_table #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_score_in   (req_score_in),
      .req_tag_in     (req_tag_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_result_kind(rsp_result_kind),
      .rsp_found      (rsp_found),
      .rsp_index_out  (rsp_index_out),
      .rsp_score_out  (rsp_score_out),
      .rsp_tag_out    (rsp_tag_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Build a report from the shadow table; a miss reports all zeros
   function automatic table_report_type make_report(logic kind, bit hit, int pos);
      table_report_type r;
      r.kind  = kind;
      r.found = hit;
      r.index = '0;
      r.score = '0;
      r.tag   = '0;
      if (hit) begin
         r.index = pos[INDEX_W-1:0];
         r.score = shadow_score[pos];
         r.tag   = shadow_tag[pos];
      end
      return r;
   endfunction

   // Apply one accepted beat to the shadow table and queue its report
   task automatic apply_table_op(input table_req_type rq);
      int                        last_pos;
      int                        best;
      int                        lo;
      int                        hi;
      int                        mid;
      bit                        hit;
      logic signed [SCORE_W-1:0] ts;
      logic [TAG_W-1:0]          tt;
      case (rq.op)
         OP_CLEAR: begin
            shadow_count = 0;
         end
         OP_LOAD: begin
            if (shadow_count < DEPTH) begin
               shadow_score[shadow_count] = rq.score;
               shadow_tag[shadow_count]   = rq.tag;
               shadow_count++;
            end
         end
         OP_SORT: begin
            // each pass moves the first maximum of the prefix to its end
            for (int pass = 0; pass + 1 < shadow_count; pass++) begin
               last_pos = shadow_count - pass - 1;
               best = 0;
               for (int z = 1; z <= last_pos; z++) begin
                  if (shadow_score[best] < shadow_score[z]) best = z;
               end
               ts = shadow_score[best];
               shadow_score[best] = shadow_score[last_pos];
               shadow_score[last_pos] = ts;
               tt = shadow_tag[best];
               shadow_tag[best] = shadow_tag[last_pos];
               shadow_tag[last_pos] = tt;
            end
            if (shadow_count == 0) pending_reports.push_back(make_report(KIND_MAX, 1'b0, 0));
            else pending_reports.push_back(make_report(KIND_MAX, 1'b1, shadow_count - 1));
         end
         default: begin
            // binary search, midpoint truncated toward zero
            lo  = 0;
            hi  = shadow_count - 1;
            hit = 1'b0;
            mid = (lo + hi) / 2;
            while (lo <= hi) begin
               if (shadow_score[mid] == rq.score) begin
                  hit = 1'b1;
                  break;
               end
               if (shadow_score[mid] < rq.score) lo = mid + 1;
               else hi = mid - 1;
               mid = (lo + hi) / 2;
            end
            pending_reports.push_back(make_report(KIND_SEARCH, hit, mid));
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Sample both channels; check report beats, then predict from request beats
   always @(posedge clock) begin
      table_report_type want;
      table_req_type    rq;
      req_took = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_reports.size() == 0) begin
               $error("report beat with no report pending");
               fail_count++;
            end else begin
               want = pending_reports.pop_front();
               check_field("result_kind", want.kind, rsp_result_kind);
               check_field("found", want.found, rsp_found);
               check_field("index_out", want.index, rsp_index_out);
               check_field("score_out", want.score, rsp_score_out);
               check_field("tag_out", want.tag, rsp_tag_out);
            end
         end
         if (req_valid && req_ready) begin
            rq.op    = op_type'(req_op);
            rq.score = req_score_in;
            rq.tag   = req_tag_in;
            apply_table_op(rq);
            req_took = 1'b1;
            req_beats++;
         end
      end
   end

   function automatic bit steady_stretch();
      return req_beats >= STEADY_LO && req_beats < STEADY_HI;
   endfunction

   // Offer request beats; hold valid and payload until accepted
   always @(negedge clock) begin
      table_req_type rq;
      if (!reset && (!req_valid || req_took)) begin
         if (req_backlog.size() != 0 && (steady_stretch() || $urandom_range(0, 99) >= 32)) begin
            rq = req_backlog.pop_front();
            req_valid    <= 1'b1;
            req_op       <= rq.op;
            req_score_in <= rq.score;
            req_tag_in   <= rq.tag;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Drive report ready; once, hold it low for a long stretch so requests back up
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && req_beats >= HOLD_AT) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= steady_stretch() || $urandom_range(0, 99) >= 32;
      end
   end

   task automatic queue_op(input op_type op, input logic signed [SCORE_W-1:0] score,
                           input logic [TAG_W-1:0] tag);
      table_req_type rq;
      rq.op    = op;
      rq.score = score;
      rq.tag   = tag;
      req_backlog.push_back(rq);
      queued++;
      if (op == OP_CLEAR) begin
         gen_count = 0;
         gen_scores.delete();
      end else if (op == OP_LOAD && gen_count < DEPTH) begin
         gen_count++;
         gen_scores.push_back(score);
      end
   endtask

   // Mix of extremes, a narrow band for ties, and full-range values
   function automatic logic signed [SCORE_W-1:0] pick_score();
      case ($urandom_range(0, 9))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2, 3, 4: return 16'($urandom_range(0, 16) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   // Mostly keys present in the table, some neighbors and some random
   function automatic logic signed [SCORE_W-1:0] pick_key();
      logic signed [SCORE_W-1:0] k;
      if (gen_scores.size() == 0) return pick_score();
      k = gen_scores[$urandom_range(0, gen_scores.size() - 1)];
      case ($urandom_range(0, 19))
         0, 1:    return k + 16'sd1;
         2, 3:    return k - 16'sd1;
         4, 5, 6: return pick_score();
         default: return k;
      endcase
   endfunction

   initial begin
      int     pick;
      int     nload;
      int     big_sets;
      int     stop_at;
      op_type op;

      // Empty table, extremes, duplicate scores and maxima, misses, clear, single entry
      queue_op(OP_SORT, 16'sd0, 16'h0000);
      queue_op(OP_SEARCH, 16'sd0, 16'hFFFF);
      queue_op(OP_LOAD, 16'sh7FFF, 16'hFFFF);
      queue_op(OP_LOAD, 16'sh8000, 16'h0000);
      queue_op(OP_LOAD, 16'sd0, 16'h1234);
      queue_op(OP_LOAD, 16'sd5, 16'h000A);
      queue_op(OP_LOAD, 16'sd5, 16'h000B);
      queue_op(OP_LOAD, 16'sh7FFF, 16'h5555);
      queue_op(OP_SORT, 16'sh7FFF, 16'hAAAA);
      queue_op(OP_SEARCH, 16'sh8000, 16'h0000);
      queue_op(OP_SEARCH, 16'sh7FFF, 16'hFFFF);
      queue_op(OP_SEARCH, 16'sd5, 16'h0000);
      queue_op(OP_SEARCH, 16'sd4, 16'h0000);
      queue_op(OP_SEARCH, -16'sd1, 16'h0000);
      queue_op(OP_CLEAR, 16'sh7FFF, 16'hFFFF);
      queue_op(OP_SORT, 16'sd0, 16'h0000);
      queue_op(OP_SEARCH, 16'sd5, 16'h0000);
      queue_op(OP_LOAD, 16'sd7, 16'h0077);
      queue_op(OP_SORT, 16'sd0, 16'h0000);
      queue_op(OP_SEARCH, 16'sd7, 16'h0000);
      queue_op(OP_SEARCH, 16'sd8, 16'h0000);

      // Random part: mostly clear/load/sort/search sequences, a few full tables, some noise
      big_sets = 0;
      stop_at  = queued + RAND_ITEMS;
      while (queued < stop_at) begin
         pick = $urandom_range(0, 99);
         if ((big_sets == 0 && queued > 200) || (pick < 3 && big_sets < 4)) begin
            big_sets++;
            nload = (big_sets == 1) ? DEPTH + 12 : $urandom_range(DEPTH - 18, DEPTH + 12);
            queue_op(OP_CLEAR, pick_score(), 16'($urandom));
            repeat (nload) queue_op(OP_LOAD, pick_score(), 16'($urandom));
            queue_op(OP_SORT, pick_score(), 16'($urandom));
            repeat (10) queue_op(OP_SEARCH, pick_key(), 16'($urandom));
            queue_op(OP_CLEAR, pick_score(), 16'($urandom));
         end else if (pick < 84) begin
            if (gen_count > 40 || $urandom_range(0, 9) != 0)
               queue_op(OP_CLEAR, pick_score(), 16'($urandom));
            repeat ($urandom_range(0, 14)) queue_op(OP_LOAD, pick_score(), 16'($urandom));
            if ($urandom_range(0, 9) != 0) queue_op(OP_SORT, pick_score(), 16'($urandom));
            repeat ($urandom_range(1, 6)) queue_op(OP_SEARCH, pick_key(), 16'($urandom));
         end else begin
            repeat ($urandom_range(1, 4)) begin
               op = op_type'($urandom_range(0, 3));
               // keep sorts of large tables rare
               if (op == OP_SORT && gen_count > 40) op = OP_SEARCH;
               queue_op(op, pick_score(), 16'($urandom));
            end
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Drain: all beats sent, all reports back, then a quiet margin
      while (req_backlog.size() != 0 || req_valid) @(negedge clock);
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      if (fail_count == 0) begin
         $display("tb_sort_then_binary_search_table passed");
      end else begin
         $display("tb_sort_then_binary_search_table failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(50_000_000);
      $display("tb_sort_then_binary_search_table failed");
      $finish;
   end

endmodule

FILE: sort_then_binary_search_table.f
hw/rtl/stbs_pkg.sv
hw/rtl/stbs_sequencer.sv
hw/rtl/stbs_datapath.sv
hw/rtl/sort_then_binary_search_table.sv
sim/tb_sort_then_binary_search_table.sv
